// ----- sv/dfsp_pkg.sv -----
// Shared types and constants of the depth frame stream parser.
package dfsp_pkg;

  localparam int unsigned PosWidth = 17;

  localparam logic [PosWidth-1:0] HEADER_BYTES = 17'd20;
  localparam logic [PosWidth-1:0] LENGTH_BIAS  = 17'd4;
  localparam logic [15:0]         MIN_LENGTH   = 16'd16;

  // Header byte positions counted from the first sync byte.
  localparam logic [4:0] POS_SYNC_FIRST  = 5'd0;
  localparam logic [4:0] POS_SYNC_SECOND = 5'd1;
  localparam logic [4:0] POS_LEN_LOW     = 5'd2;
  localparam logic [4:0] POS_LEN_HIGH    = 5'd3;
  localparam logic [4:0] POS_MODE        = 5'd5;
  localparam logic [4:0] POS_SENSOR_TEMP = 5'd6;
  localparam logic [4:0] POS_DRIVER_TEMP = 5'd7;
  localparam logic [4:0] POS_EXPOSURE_0  = 5'd8;
  localparam logic [4:0] POS_EXPOSURE_1  = 5'd9;
  localparam logic [4:0] POS_EXPOSURE_2  = 5'd10;
  localparam logic [4:0] POS_EXPOSURE_3  = 5'd11;
  localparam logic [4:0] POS_ERROR       = 5'd12;
  localparam logic [4:0] POS_ROWS        = 5'd14;
  localparam logic [4:0] POS_COLS        = 5'd15;
  localparam logic [4:0] POS_FRAME_LOW   = 5'd16;
  localparam logic [4:0] POS_FRAME_HIGH  = 5'd17;

  // Configuration register indexes.
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_END_MARKER  = 2'd2;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_FRAME_OK = 3'd1,
    KIND_SUM_BAD  = 3'd2,
    KIND_END_BAD  = 3'd3,
    KIND_LEN_BAD  = 3'd4
  } result_kind_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] end_marker;
  } cfg_t;

  typedef struct packed {
    logic [15:0] frame_counter;
    logic [7:0]  row_total;
    logic [7:0]  col_total;
    logic [7:0]  mode_code;
    logic [7:0]  sensor_heat;
    logic [7:0]  driver_heat;
    logic [7:0]  status_byte;
    logic [31:0] exposure_value;
  } header_t;

  typedef struct packed {
    logic         emit;
    result_kind_t kind;
    logic [7:0]   payload_byte;
    logic [15:0]  payload_index;
    logic [15:0]  data_length;
  } step_res_t;

endpackage

// ----- sv/dfsp_channels.sv -----
// Handshake channels of the depth frame stream parser.
interface dfsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dfsp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [15:0] data_length;
  logic [15:0] frame_counter;
  logic [7:0]  row_total;
  logic [7:0]  col_total;
  logic [7:0]  mode_code;
  logic [7:0]  sensor_heat;
  logic [7:0]  driver_heat;
  logic [7:0]  status_byte;
  logic [31:0] exposure_value;

  modport source (
    output valid, output result_kind, output payload_byte, output payload_index,
    output data_length, output frame_counter, output row_total, output col_total,
    output mode_code, output sensor_heat, output driver_heat, output status_byte,
    output exposure_value, input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input payload_index,
    input data_length, input frame_counter, input row_total, input col_total,
    input mode_code, input sensor_heat, input driver_heat, input status_byte,
    input exposure_value, output ready
  );
endinterface

// ----- sv/dfsp_parser_core.sv -----
// Frame parser state: hunt, sync, length, header capture, payload, checksum and end marker.
module dfsp_parser_core import dfsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output step_res_t  step,
  output header_t    header
);

  logic                hunting, hunting_next;
  logic [PosWidth-1:0] position, position_next;
  logic [15:0]         length_held, length_held_next;
  logic [7:0]          running_sum, running_sum_next;
  header_t             header_next;

  logic [PosWidth-1:0] sum_pos;
  logic [PosWidth-1:0] end_pos;
  logic [15:0]         len_full;
  logic                advance;

  assign sum_pos  = {1'b0, length_held} + LENGTH_BIAS;
  assign end_pos  = sum_pos + 17'd1;
  assign len_full = {rx_byte, length_held[7:0]};

  always_comb begin
    hunting_next      = hunting;
    position_next     = position;
    length_held_next  = length_held;
    running_sum_next  = running_sum;
    header_next       = header;
    advance           = 1'b0;
    step.emit          = 1'b0;
    step.kind          = KIND_PAYLOAD;
    step.payload_byte  = 8'd0;
    step.payload_index = 16'd0;
    step.data_length   = length_held;

    if (hunting) begin
      if (rx_byte == cfg.end_marker) begin
        hunting_next = 1'b0;
      end
      position_next    = '0;
      length_held_next = '0;
      running_sum_next = '0;
    end else if (position >= HEADER_BYTES) begin
      position_next    = '0;
      length_held_next = '0;
      running_sum_next = '0;
      if (length_held < MIN_LENGTH) begin
        // Cannot arise from a checked header; the frame is simply dropped.
      end else if (position < sum_pos) begin
        advance            = 1'b1;
        step.emit          = 1'b1;
        step.kind          = KIND_PAYLOAD;
        step.payload_byte  = rx_byte;
        step.payload_index = 16'(position - HEADER_BYTES);
      end else if (position == sum_pos) begin
        if (running_sum == rx_byte) begin
          position_next    = position + 17'd1;
          length_held_next = length_held;
          running_sum_next = running_sum;
        end else begin
          hunting_next = 1'b1;
          step.emit    = 1'b1;
          step.kind    = KIND_SUM_BAD;
        end
      end else if (position == end_pos) begin
        step.emit = 1'b1;
        if (rx_byte == cfg.end_marker) begin
          step.kind = KIND_FRAME_OK;
        end else begin
          step.kind    = KIND_END_BAD;
          hunting_next = 1'b1;
        end
      end
    end else begin
      advance = 1'b1;
      unique case (position[4:0])
        POS_SYNC_FIRST: begin
          if (rx_byte != cfg.sync_first) advance = 1'b0;
        end
        POS_SYNC_SECOND: begin
          if (rx_byte != cfg.sync_second) advance = 1'b0;
        end
        POS_LEN_LOW:     length_held_next = {8'd0, rx_byte};
        POS_LEN_HIGH: begin
          length_held_next = len_full;
          if (len_full < MIN_LENGTH) begin
            advance          = 1'b0;
            step.emit        = 1'b1;
            step.kind        = KIND_LEN_BAD;
            step.data_length = len_full;
          end
        end
        POS_MODE:        header_next.mode_code   = rx_byte;
        POS_SENSOR_TEMP: header_next.sensor_heat = rx_byte;
        POS_DRIVER_TEMP: header_next.driver_heat = rx_byte;
        POS_EXPOSURE_0:  header_next.exposure_value[7:0]   = rx_byte;
        POS_EXPOSURE_1:  header_next.exposure_value[15:8]  = rx_byte;
        POS_EXPOSURE_2:  header_next.exposure_value[23:16] = rx_byte;
        POS_EXPOSURE_3:  header_next.exposure_value[31:24] = rx_byte;
        POS_ERROR:       header_next.status_byte = rx_byte;
        POS_ROWS:        header_next.row_total   = rx_byte;
        POS_COLS:        header_next.col_total   = rx_byte;
        POS_FRAME_LOW:   header_next.frame_counter[7:0]  = rx_byte;
        POS_FRAME_HIGH:  header_next.frame_counter[15:8] = rx_byte;
        default: ;
      endcase
      if (!advance) begin
        position_next    = '0;
        length_held_next = '0;
        running_sum_next = '0;
      end
    end

    if (advance) begin
      position_next    = position + 17'd1;
      running_sum_next = running_sum + rx_byte;
      if (position >= HEADER_BYTES) begin
        length_held_next = length_held;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunting     <= 1'b1;
      position    <= '0;
      length_held <= '0;
      running_sum <= '0;
      header      <= '0;
    end else if (accept) begin
      hunting     <= hunting_next;
      position    <= position_next;
      length_held <= length_held_next;
      running_sum <= running_sum_next;
      header      <= header_next;
    end
  end

endmodule

// ----- sv/depth_frame_stream_parser_unit.sv -----
// Top level of the depth frame stream parser: configuration, core and result register.
//
// Takes one received byte per transaction on rx and may take a byte in every clock
// cycle. After reset the parser hunts for the end marker, then matches two sync bytes
// and a little-endian length, captures the header and delivers each payload byte with
// its index as a result, followed by a frame ok, checksum bad, end bad or length bad
// result. Each byte is processed in the cycle it is accepted, and a result appears on
// res in the next cycle from a single output register; rx.ready drops only while that
// register holds a result that res has not taken. The three 8-bit registers (sync
// first, sync second, end marker) are written through cfg_we, cfg_index and cfg_data.
module depth_frame_stream_parser_unit import dfsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dfsp_byte_if.sink  rx,
  dfsp_result_if.source res,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t      cfg;
  step_res_t step;
  header_t   header;
  logic      rx_accept;
  logic      out_valid;
  step_res_t out_res;
  header_t   out_header;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first  <= 8'h00;
      cfg.sync_second <= 8'hFF;
      cfg.end_marker  <= 8'hDD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_FIRST:  cfg.sync_first  <= cfg_data;
        REG_SYNC_SECOND: cfg.sync_second <= cfg_data;
        REG_END_MARKER:  cfg.end_marker  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rx.ready  = !out_valid || res.ready;
  assign rx_accept = rx.valid && rx.ready;

  dfsp_parser_core u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (rx_accept),
    .rx_byte (rx.rx_byte),
    .cfg     (cfg),
    .step    (step),
    .header  (header)
  );

  // The result register captures the header register as it stands before the byte is applied.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rx_accept && step.emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_accept && step.emit) begin
      out_res    <= step;
      out_header <= header;
    end
  end

  assign res.valid          = out_valid;
  assign res.result_kind    = out_res.kind;
  assign res.payload_byte   = out_res.payload_byte;
  assign res.payload_index  = out_res.payload_index;
  assign res.data_length    = out_res.data_length;
  assign res.frame_counter  = out_header.frame_counter;
  assign res.row_total      = out_header.row_total;
  assign res.col_total      = out_header.col_total;
  assign res.mode_code      = out_header.mode_code;
  assign res.sensor_heat    = out_header.sensor_heat;
  assign res.driver_heat    = out_header.driver_heat;
  assign res.status_byte    = out_header.status_byte;
  assign res.exposure_value = out_header.exposure_value;

  // A waiting result must never be overwritten by a new byte.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |-> !rx_accept)
    else $error("result register overwritten while stalled");

  // Payload indexes stay no higher than the length field minus 16.
  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.kind == KIND_PAYLOAD) |->
      ({1'b0, out_res.payload_index} + 17'd16 < {1'b0, out_res.data_length} + 17'd1))
    else $error("payload index beyond frame length");

  // Only a short length field is reported as length bad.
  a_len_bad_short: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.kind == KIND_LEN_BAD) |-> (out_res.data_length < MIN_LENGTH))
    else $error("length bad reported for a valid length");

endmodule

// ----- tb/sv/dfsp_frame_compare.sv -----
// Predicts the parser's results from the observed byte and register traffic and compares them.
`timescale 1ns / 100ps
module dfsp_frame_compare import dfsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dfsp_byte_if       rx,
  dfsp_result_if     res,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         outstanding
);

  typedef struct packed {
    result_kind_t kind;
    logic [7:0]   pbyte;
    logic [15:0]  pindex;
    logic [15:0]  length;
    header_t      hdr;
  } frame_result_t;

  cfg_t                regs;
  logic                hunting;
  logic [PosWidth-1:0] position;
  logic [15:0]         length_held;
  logic [7:0]          running_sum;
  header_t             held_hdr;
  frame_result_t       frame_results_q[$];
  frame_result_t       got;
  frame_result_t       want;
  int                  fail_count = 0;

  task automatic clear_frame();
    position    = '0;
    length_held = '0;
    running_sum = '0;
  endtask

  // Advances the parser state by one received byte and queues the result it causes.
  task automatic advance_parser(input logic [7:0] b);
    frame_result_t       r;
    logic                emit;
    logic                take;
    logic [PosWidth-1:0] span;
    span     = {1'b0, length_held} + LENGTH_BIAS;
    r        = '0;
    r.length = length_held;
    emit     = 1'b0;
    take     = 1'b1;
    if (hunting) begin
      if (b == regs.end_marker) hunting = 1'b0;
      clear_frame();
    end else if (position >= HEADER_BYTES) begin
      if (length_held < MIN_LENGTH) begin
        clear_frame();
      end else if (position < span) begin
        emit     = 1'b1;
        r.kind   = KIND_PAYLOAD;
        r.pbyte  = b;
        r.pindex = 16'(position - HEADER_BYTES);
        running_sum += b;
        position++;
      end else if (position == span) begin
        if (running_sum == b) begin
          position++;
        end else begin
          hunting = 1'b1;
          clear_frame();
          emit   = 1'b1;
          r.kind = KIND_SUM_BAD;
        end
      end else if (position == span + 1'b1) begin
        clear_frame();
        emit = 1'b1;
        if (b == regs.end_marker) begin
          r.kind = KIND_FRAME_OK;
        end else begin
          r.kind  = KIND_END_BAD;
          hunting = 1'b1;
        end
      end else begin
        clear_frame();
      end
    end else begin
      case (position[4:0])
        POS_SYNC_FIRST:  take = (b == regs.sync_first);
        POS_SYNC_SECOND: take = (b == regs.sync_second);
        POS_LEN_LOW:     length_held = {8'h00, b};
        POS_LEN_HIGH: begin
          length_held[15:8] = b;
          if (length_held < MIN_LENGTH) begin
            emit     = 1'b1;
            r.kind   = KIND_LEN_BAD;
            r.length = length_held;
            take     = 1'b0;
          end
        end
        POS_MODE:        held_hdr.mode_code = b;
        POS_SENSOR_TEMP: held_hdr.sensor_heat = b;
        POS_DRIVER_TEMP: held_hdr.driver_heat = b;
        POS_EXPOSURE_0:  held_hdr.exposure_value[7:0] = b;
        POS_EXPOSURE_1:  held_hdr.exposure_value[15:8] = b;
        POS_EXPOSURE_2:  held_hdr.exposure_value[23:16] = b;
        POS_EXPOSURE_3:  held_hdr.exposure_value[31:24] = b;
        POS_ERROR:       held_hdr.status_byte = b;
        POS_ROWS:        held_hdr.row_total = b;
        POS_COLS:        held_hdr.col_total = b;
        POS_FRAME_LOW:   held_hdr.frame_counter[7:0] = b;
        POS_FRAME_HIGH:  held_hdr.frame_counter[15:8] = b;
        default: ;
      endcase
      if (take) begin
        running_sum += b;
        position++;
      end else begin
        clear_frame();
      end
    end
    if (emit) begin
      r.hdr = held_hdr;
      frame_results_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs    = {8'h00, 8'hFF, 8'hDD};
      hunting = 1'b1;
      clear_frame();
      held_hdr = '0;
      frame_results_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SYNC_FIRST:  regs.sync_first = cfg_data;
          REG_SYNC_SECOND: regs.sync_second = cfg_data;
          REG_END_MARKER:  regs.end_marker = cfg_data;
          default: ;
        endcase
      end
      // A result leaves no earlier than the cycle after its byte, so it is
      // matched before the byte of this same edge is predicted.
      if (res.valid && res.ready) begin
        got.kind                = result_kind_t'(res.result_kind);
        got.pbyte               = res.payload_byte;
        got.pindex              = res.payload_index;
        got.length              = res.data_length;
        got.hdr.frame_counter   = res.frame_counter;
        got.hdr.row_total       = res.row_total;
        got.hdr.col_total       = res.col_total;
        got.hdr.mode_code       = res.mode_code;
        got.hdr.sensor_heat     = res.sensor_heat;
        got.hdr.driver_heat     = res.driver_heat;
        got.hdr.status_byte     = res.status_byte;
        got.hdr.exposure_value  = res.exposure_value;
        if (frame_results_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected result: kind %0d byte %h index %0d length %0d header %h",
                     got.kind, got.pbyte, got.pindex, got.length, got.hdr);
          end
          fail_count++;
        end else begin
          want = frame_results_q.pop_front();
          if (got.kind !== want.kind || got.pbyte !== want.pbyte ||
              got.pindex !== want.pindex || got.length !== want.length ||
              got.hdr !== want.hdr) begin
            if (fail_count < 10) begin
              $display("result mismatch: expected kind %0d byte %h index %0d length %0d",
                       want.kind, want.pbyte, want.pindex, want.length);
              $display("  expected header %h", want.hdr);
              $display("  actual   kind %0d byte %h index %0d length %0d",
                       got.kind, got.pbyte, got.pindex, got.length);
              $display("  actual   header %h", got.hdr);
            end
            fail_count++;
          end
        end
      end
      if (rx.valid && rx.ready) advance_parser(rx.rx_byte);
    end
    mismatches  <= fail_count;
    outstanding <= frame_results_q.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Stimulus, configuration and verdict for the depth frame stream parser.
`timescale 1ns / 100ps
module testbench;
  import dfsp_pkg::*;

  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 6;
  // Longest quiet stretch is the receiver hold-off; random gaps stay far below it.
  localparam int StallLimit   = 5000;
  localparam int PhaseBytes   = 300;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;
  typedef enum logic [1:0] {
    FRAME_GOOD, FRAME_SUM_BAD, FRAME_END_BAD, FRAME_MARKER_SWAP
  } frame_fault_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  int          mismatches;
  int          outstanding;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned stall_count;
  logic        hold_request = 1'b0;
  logic [7:0]  sync_first_val = 8'h00;
  logic [7:0]  sync_second_val = 8'hFF;
  logic [7:0]  end_marker_val = 8'hDD;

  dfsp_byte_if   rx_ch();
  dfsp_result_if res_ch();

  depth_frame_stream_parser_unit dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dfsp_frame_compare frame_compare (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx_ch),
    .res         (res_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    stall_count = 0;
    while (stall_count < StallLimit) begin
      @(posedge clk);
      if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        stall_count = 0;
      end else begin
        stall_count++;
      end
    end
    $display("FAIL");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        res_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic push_rx_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Lets every transaction in flight drain before the parser is left alone.
  task automatic settle();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SYNC_FIRST:  sync_first_val = val;
      REG_SYNC_SECOND: sync_second_val = val;
      default:         end_marker_val = val;
    endcase
  endtask

  task automatic set_config(input logic [7:0] sf, input logic [7:0] ss, input logic [7:0] em);
    write_reg(REG_SYNC_FIRST, sf);
    write_reg(REG_SYNC_SECOND, ss);
    write_reg(REG_END_MARKER, em);
  endtask

  // Sends one frame; a length below the minimum stops after the length field.
  task automatic send_frame(input logic [15:0] len, input fill_t fill,
                            input frame_fault_t fault);
    logic [7:0]  sum;
    logic [7:0]  b;
    int unsigned k;
    int unsigned span;
    sum  = '0;
    span = 32'(len) + 4;
    for (k = 0; k < span; k++) begin
      case (k)
        0: b = sync_first_val;
        1: b = sync_second_val;
        2: b = len[7:0];
        3: b = len[15:8];
        default: begin
          case (fill)
            FILL_ONES:  b = 8'hFF;
            FILL_ZEROS: b = 8'h00;
            default:    b = 8'($urandom);
          endcase
        end
      endcase
      sum += b;
      push_rx_byte(b);
      if (k == 3 && len < MIN_LENGTH) return;
    end
    if (fault == FRAME_SUM_BAD) begin
      push_rx_byte(sum + 8'($urandom_range(1, 255)));
      // The parser hunts again, so hand it an end marker.
      push_rx_byte(end_marker_val);
      return;
    end
    push_rx_byte(sum);
    // The end marker changes while the parser waits for the frame end.
    if (fault == FRAME_MARKER_SWAP) write_reg(REG_END_MARKER, ~end_marker_val);
    if (fault == FRAME_END_BAD) begin
      push_rx_byte(end_marker_val ^ 8'($urandom_range(1, 255)));
      push_rx_byte(end_marker_val);
    end else begin
      push_rx_byte(end_marker_val);
    end
  endtask

  task automatic random_traffic(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n;
    logic [15:0] len;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? 16'($urandom_range(16, 300))
                                      : 16'($urandom_range(16, 40));
      if (pick < 66) begin
        send_frame(len, FILL_RANDOM, FRAME_GOOD);
      end else if (pick < 74) begin
        send_frame(len, FILL_RANDOM, FRAME_SUM_BAD);
      end else if (pick < 82) begin
        send_frame(len, FILL_RANDOM, FRAME_END_BAD);
      end else if (pick < 88) begin
        send_frame(16'($urandom_range(0, 15)), FILL_RANDOM, FRAME_GOOD);
      end else if (pick < 94) begin
        n = $urandom_range(1, 6);
        repeat (n) push_rx_byte(8'($urandom));
        push_rx_byte(end_marker_val);
      end else begin
        push_rx_byte(sync_first_val);
        push_rx_byte(sync_second_val ^ 8'($urandom_range(1, 255)));
      end
    end
  endtask

  initial begin
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_SYNC_FIRST;
    cfg_data      <= 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the reset register values and no idling.
    push_rx_byte(8'h00);
    push_rx_byte(8'hFF);
    push_rx_byte(8'h5A);
    push_rx_byte(end_marker_val);
    send_frame(16'd16, FILL_ONES, FRAME_GOOD);
    send_frame(16'd16, FILL_ZEROS, FRAME_GOOD);
    send_frame(16'd17, FILL_RANDOM, FRAME_SUM_BAD);
    send_frame(16'd20, FILL_RANDOM, FRAME_END_BAD);
    send_frame(16'd15, FILL_RANDOM, FRAME_GOOD);
    send_frame(16'd0, FILL_ZEROS, FRAME_GOOD);
    push_rx_byte(sync_first_val ^ 8'h01);
    push_rx_byte(sync_first_val);
    push_rx_byte(sync_second_val ^ 8'h01);
    send_frame(16'h0100, FILL_RANDOM, FRAME_GOOD);
    send_frame(16'd18, FILL_RANDOM, FRAME_MARKER_SWAP);

    send_idle_pct = 36;
    recv_idle_pct = 52;
    set_config(8'hFF, 8'h00, 8'h00);
    // The sender keeps offering bytes while results back up behind the hold-off.
    hold_request = 1'b1;
    send_frame(16'd48, FILL_RANDOM, FRAME_GOOD);
    random_traffic(PhaseBytes);

    send_idle_pct = 52;
    recv_idle_pct = 36;
    set_config(8'($urandom), 8'($urandom), 8'($urandom));
    random_traffic(PhaseBytes);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(8'h00, 8'hFF, 8'hFF);
    random_traffic(PhaseBytes);

    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
